/* src/fifo_multi_server_dispatcher_defines.svh */
// assertion macros for the multi-server fifo dispatcher
// expects clk and rst in scope where the macros are used
`ifndef FIFO_MULTI_SERVER_DISPATCHER_DEFINES_SVH
`define FIFO_MULTI_SERVER_DISPATCHER_DEFINES_SVH

// consequence checked in the same cycle as the antecedent
`define FMSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define FMSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fmsd_pkg.sv */
// shared types and defaults for the multi-server fifo dispatcher
// no dependencies
`timescale 1ns / 1ps

package fmsd_pkg;

  localparam int DEF_QUEUE_DEPTH = 128;
  localparam int DEF_SERVERS     = 2;

  // input word as it arrives on the stream, lowest field last
  typedef struct packed {
    logic [2:0] pad;
    logic [3:0] service_length;
    logic       arrive;
  } cmd_word_t;

  // classified tick command handed from front to back
  typedef struct packed {
    logic       arrive;
    logic [3:0] svc;
  } cmd_t;

  // one job queue entry
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] stamp;
    logic [3:0]  svc;
  } job_t;

  // one result word, lowest field last
  typedef struct packed {
    logic [6:0]  pad;
    logic        overflow;
    logic [6:0]  queue_length;
    logic [15:0] arrival_count;
    logic [31:0] accum_wait;
    logic [15:0] wait_ticks;
    logic [3:0]  remaining;
    logic [15:0] job_id;
    logic        busy_res;
    logic        started;
    logic [2:0]  server_index;
  } result_t;

endpackage

/* src/fmsd_front.sv */
// front end: accepts tick words and keeps them in a two-entry command queue
// depends on fmsd_pkg
`timescale 1ns / 1ps

module fmsd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  fmsd_pkg::cmd_word_t s_axis_tdata,   // arrive, service_length, pad
  output logic                cmd_valid,
  output fmsd_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);
  import fmsd_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign s_axis_tready = (count != 2'd2);
  assign cmd_valid     = (count != 2'd0);
  assign cmd           = q[rd_ptr];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{arrive: s_axis_tdata.arrive, svc: s_axis_tdata.service_length};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* src/fmsd_back.sv */
// back end: job queue memory, server state, one server step per unstalled cycle
// depends on fmsd_pkg
`timescale 1ns / 1ps

module fmsd_back #(
  parameter int QUEUE_DEPTH = fmsd_pkg::DEF_QUEUE_DEPTH,
  parameter int SERVERS     = fmsd_pkg::DEF_SERVERS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  fmsd_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output fmsd_pkg::result_t m_axis_tdata,
  output logic              m_axis_tlast
);
  import fmsd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int SRV_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam int QL_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [SRV_W-1:0] SRV_LAST = SRV_W'(SERVERS - 1);
  localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  job_t        mem [QUEUE_DEPTH];
  job_t        rd_data;
  job_t        fwd_data;
  logic        fwd_valid;

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [PTR_W-1:0] rd_addr;
  logic [15:0]      tick;
  logic [15:0]      next_id, next_id_next;
  logic [31:0]      wait_sum, wait_sum_next;
  logic             dropped, dropped_next;
  logic [SRV_W-1:0] srv;
  logic [3:0]       srv_rem [SERVERS];
  logic [15:0]      srv_job [SERVERS];

  logic             step;
  logic             first;
  logic             wr_en;
  logic             bypass;
  job_t             wr_entry;
  job_t             head_entry;
  logic [3:0]       rem_cur, rem_out;
  logic             started, busy;
  logic [15:0]      jid, wait_val;
  logic [32:0]      sum_wide;
  logic [CNT_W-1:0] cnt;
  logic [QL_W-1:0]  cnt_ext;
  result_t          res;

  assign step    = cmd_valid && (!m_axis_tvalid || m_axis_tready);
  assign first   = (srv == '0);
  assign cmd_pop = step && (srv == SRV_LAST);
  assign rem_cur = srv_rem[srv];

  // enqueue on the first server step of a tick
  always_comb begin
    tail_next    = tail;
    next_id_next = next_id;
    dropped_next = dropped;
    wr_en        = 1'b0;
    bypass       = 1'b0;
    wr_entry     = '{id: next_id, stamp: tick, svc: cmd.svc};
    if (step && first) begin
      dropped_next = 1'b0;
      if (cmd.arrive) begin
        next_id_next = next_id + 16'd1;
        if (wrap_next(tail) == head) begin
          dropped_next = 1'b1;
        end else begin
          tail_next = wrap_next(tail);
          wr_en     = 1'b1;
          bypass    = (head == tail);
        end
      end
    end
  end

  // empty queue taking the new arrival reads it straight from the input
  assign head_entry = bypass ? wr_entry : (fwd_valid ? fwd_data : rd_data);

  // one server step
  always_comb begin
    head_next     = head;
    started       = 1'b0;
    busy          = 1'b0;
    jid           = '0;
    rem_out       = rem_cur;
    wait_val      = '0;
    wait_sum_next = wait_sum;
    sum_wide      = {1'b0, wait_sum} + 33'(wait_val);
    if (step) begin
      if (rem_cur != 4'd0) begin
        rem_out = rem_cur - 4'd1;
        busy    = 1'b1;
        jid     = srv_job[srv];
      end else if (head != tail_next) begin
        head_next     = wrap_next(head);
        started       = 1'b1;
        busy          = 1'b1;
        jid           = head_entry.id;
        rem_out       = head_entry.svc;
        wait_val      = tick - head_entry.stamp;
        sum_wide      = {1'b0, wait_sum} + 33'(wait_val);
        wait_sum_next = sum_wide[32] ? '1 : sum_wide[31:0];
      end
    end
  end

  assign rd_addr = wrap_next(head_next);

  always_comb begin
    if (tail_next >= head_next) begin
      cnt = CNT_W'(tail_next) - CNT_W'(head_next);
    end else begin
      cnt = CNT_W'(tail_next) + CNT_DEPTH - CNT_W'(head_next);
    end
    cnt_ext = QL_W'(cnt);
  end

  always_comb begin
    res               = '0;
    res.server_index  = 3'(srv);
    res.started       = started;
    res.busy_res      = busy;
    res.job_id        = jid;
    res.remaining     = rem_out;
    res.wait_ticks    = wait_val;
    res.accum_wait    = wait_sum_next;
    res.arrival_count = next_id_next;
    res.queue_length  = cnt_ext[6:0];
    res.overflow      = dropped_next;
  end

  // job memory with registered read of the next head entry
  always_ff @(posedge clk) begin
    if (wr_en) mem[tail_next] <= wr_entry;
    rd_data  <= mem[rd_addr];
    fwd_data <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en && (tail_next == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      tick     <= '0;
      next_id  <= '0;
      wait_sum <= '0;
      dropped  <= 1'b0;
      srv      <= '0;
      for (int i = 0; i < SERVERS; i++) begin
        srv_rem[i] <= '0;
        srv_job[i] <= '0;
      end
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      next_id  <= next_id_next;
      wait_sum <= wait_sum_next;
      dropped  <= dropped_next;
      if (step) begin
        srv_rem[srv] <= rem_out;
        if (started) srv_job[srv] <= head_entry.id;
        if (srv == SRV_LAST) begin
          srv  <= '0;
          tick <= tick + 16'd1;
        end else begin
          srv <= srv + SRV_W'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= res;
      m_axis_tlast <= (srv == SRV_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

/* src/fifo_multi_server_dispatcher.sv */
// top level of the multi-server fifo dispatcher
// depends on fmsd_pkg, fmsd_front, fmsd_back and the assertion macro header
`timescale 1ns / 1ps
`include "fifo_multi_server_dispatcher_defines.svh"

// Each input word is one simulation tick: it may carry one job arrival with
// its service length. The arrival gets the next 16-bit id and the tick stamp
// and joins a circular job queue holding at most QUEUE_DEPTH-1 jobs; on a
// full queue the job is counted but dropped and overflow is set for the tick.
// The servers are then visited in index order, and each tick produces exactly
// SERVERS result words, the last one marked with tlast. One server is handled
// per cycle while results are taken, by the single server step unit sharing
// the job queue memory read port. A two-word command queue sits in front, so
// new ticks are taken while results are still being produced, and a registered
// output stage holds each result until taken. The first result of a tick
// passes the command queue and the output register after its word is accepted,
// and the others follow one per cycle while results are taken.
// The job memory needs no clearing after reset.
module fifo_multi_server_dispatcher #(
  parameter int QUEUE_DEPTH = fmsd_pkg::DEF_QUEUE_DEPTH,  // 4 .. 4096 slots
  parameter int SERVERS     = fmsd_pkg::DEF_SERVERS       // 1 .. 8 servers
) (
  input  logic                clk,
  input  logic                rst,
  // tick input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // fields from bit 0: arrive, service_length, zero pad
  input  fmsd_pkg::cmd_word_t s_axis_tdata,
  // per-server results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // fields from bit 0: server_index, started, busy_res, job_id, remaining,
  // wait_ticks, accum_wait, arrival_count, queue_length, overflow, zero pad
  output fmsd_pkg::result_t   m_axis_tdata,
  output logic                m_axis_tlast       // result of the highest server
);
  import fmsd_pkg::*;

  // front to back command path
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // terms used by the checks at the end
  logic       out_mid;
  logic       top_server;
  logic       idle_out;
  logic       idle_clean;
  logic [2:0] out_srv;

  // front: accept and classify tick words
  fmsd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // back: job queue, servers and output register
  fmsd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SERVERS     (SERVERS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign out_srv    = m_axis_tdata.server_index;
  assign out_mid    = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign top_server = (out_srv == 3'(SERVERS - 1));
  assign idle_out   = m_axis_tvalid && !m_axis_tdata.busy_res;
  assign idle_clean = !m_axis_tdata.started && (m_axis_tdata.job_id == 16'd0)
                      && (m_axis_tdata.wait_ticks == 16'd0);

  // tlast marks exactly the highest server
  `FMSD_ASSERT_SAME(a_last_on_top_server, m_axis_tvalid, m_axis_tlast == top_server, "bad tlast")

  // an idle server reports no job, no start and no wait
  `FMSD_ASSERT_SAME(a_idle_result_clean, idle_out, idle_clean, "unclean idle")

  // within a tick the servers follow in index order
  `FMSD_ASSERT_NEXT(a_srv_order, out_mid, !m_axis_tvalid || out_srv == $past(out_srv) + 3'd1, "order")

endmodule

/* dv/fifo_multi_server_dispatcher_test.sv */
// self-checking testbench for the multi-server fifo dispatcher
// depends on fmsd_pkg and fifo_multi_server_dispatcher; a job-queue predictor checks every result
`timescale 1ns / 1ps

module fifo_multi_server_dispatcher_test;
  import fmsd_pkg::*;

  localparam int DEPTH        = DEF_QUEUE_DEPTH;
  localparam int NSRV         = DEF_SERVERS;
  localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either side
  localparam int REPORT_LIMIT = 10;     // mismatches printed in full
  localparam int TAIL_CYCLES  = 20;     // quiet time after the last expected result

  // one expected result word plus its tlast
  typedef struct packed {
    result_t word;
    logic    last;
  } report_t;

  // directed stimulus row; the server 0 result is typed in only where typed is set
  typedef struct packed {
    logic        arrive;
    logic [3:0]  svc;
    logic        typed;
    logic        started;
    logic        busy;
    logic [15:0] job_id;
    logic [3:0]  remaining;
    logic [15:0] wait_ticks;
    logic [31:0] total;
    logic [15:0] arrivals;
    logic [6:0]  qlen;
    logic        ovf;
  } tick_row_t;

  localparam int N_DIRECTED = 16;

  tick_row_t directed_rows [N_DIRECTED] = '{
    // idle tick right after reset, no arrival and a zero service length
    '{1'b0, 4'd0,  1'b1, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    // longest job goes straight to server 0
    '{1'b1, 4'd15, 1'b1, 1'b1, 1'b1, 16'd0, 4'd15, 16'd0, 32'd0, 16'd1, 7'd0, 1'b0},
    // server 0 counts down while the new job still sits in the queue
    '{1'b1, 4'd0,  1'b1, 1'b0, 1'b1, 16'd0, 4'd14, 16'd0, 32'd0, 16'd2, 7'd1, 1'b0},
    // zero-length jobs: server 1 is free again on the next tick
    '{1'b1, 4'd0,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b0, 4'd15, 1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b1, 4'd5,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b1, 4'd10, 1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    // both servers stay busy through these rows, so jobs wait in the queue
    '{1'b1, 4'd3,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b1, 4'd15, 1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b1, 4'd0,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b1, 4'd1,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b0, 4'd8,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b1, 4'd7,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b1, 4'd14, 1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0},
    '{1'b0, 4'd0,  1'b0, 1'b0, 1'b0, 16'd0, 4'd0,  16'd0, 32'd0, 16'd0, 7'd0, 1'b0}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      s_axis_tvalid;
  logic      s_axis_tready;
  cmd_word_t s_axis_tdata;    // fields from bit 0: arrive, service_length, zero pad
  logic      m_axis_tvalid;
  logic      m_axis_tready = 1'b0;
  result_t   m_axis_tdata;    // fields from bit 0: server_index, started, busy_res, job_id,
                              // remaining, wait_ticks, accum_wait, arrival_count,
                              // queue_length, overflow, zero pad
  logic      m_axis_tlast;

  // while set, neither side inserts idle cycles
  bit steady = 1'b0;

  // predictor state: job queue, tick stamp, id counter, servers, wait total
  job_t        job_mem [DEPTH];
  int unsigned q_head;
  int unsigned q_tail;
  logic [15:0] tick_now;
  logic [15:0] id_next;
  logic [3:0]  busy_left [NSRV];
  logic [15:0] held_job [NSRV];
  logic [31:0] wait_total;

  report_t pending_reports [$];

  int unsigned ticks_sent;
  int unsigned arrivals_seen;
  int unsigned drops_seen;
  int unsigned id_wraps;
  int unsigned peak_queue;
  int unsigned reports_seen;
  int unsigned failures;
  int unsigned idle_cycles;

  fifo_multi_server_dispatcher #(
    .QUEUE_DEPTH(DEPTH),
    .SERVERS    (NSRV)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // advance the queue model by one tick and queue one result per server
  task automatic serve_tick(input logic arr, input logic [3:0] svc);
    logic        dropped;
    logic [15:0] this_wait;
    logic [32:0] wide_sum;
    job_t        head_job;
    report_t     rep;
    int unsigned depth_now;
    dropped = 1'b0;
    if (arr) begin
      arrivals_seen++;
      // one slot always stays empty, so a full queue drops the job but it still takes an id
      if ((q_tail + 1) % DEPTH == q_head) begin
        dropped = 1'b1;
        drops_seen++;
      end else begin
        q_tail = (q_tail + 1) % DEPTH;
        job_mem[q_tail] = '{id: id_next, stamp: tick_now, svc: svc};
      end
      id_next = id_next + 16'd1;
      if (id_next == 16'd0) id_wraps++;
    end
    for (int s = 0; s < NSRV; s++) begin
      rep = '0;
      rep.word.server_index = 3'(s);
      if (busy_left[s] != 4'd0) begin
        busy_left[s] = busy_left[s] - 4'd1;
        rep.word.busy_res = 1'b1;
        rep.word.job_id = held_job[s];
      end else if (q_head != q_tail) begin
        q_head = (q_head + 1) % DEPTH;
        head_job = job_mem[q_head];
        held_job[s] = head_job.id;
        busy_left[s] = head_job.svc;
        // wait is taken modulo 2^16 across the tick wrap
        this_wait = tick_now - head_job.stamp;
        wide_sum = {1'b0, wait_total} + {17'd0, this_wait};
        wait_total = wide_sum[32] ? '1 : wide_sum[31:0];
        rep.word.started = 1'b1;
        rep.word.busy_res = 1'b1;
        rep.word.job_id = head_job.id;
        rep.word.wait_ticks = this_wait;
      end
      depth_now = (q_tail + DEPTH - q_head) % DEPTH;
      if (depth_now > peak_queue) peak_queue = depth_now;
      rep.word.remaining = busy_left[s];
      rep.word.accum_wait = wait_total;
      rep.word.arrival_count = id_next;
      rep.word.queue_length = 7'(depth_now);
      rep.word.overflow = dropped;
      rep.last = (s == NSRV - 1);
      pending_reports.push_back(rep);
    end
    tick_now = tick_now + 16'd1;
  endtask

  // present one tick word with random gaps in front unless steady is set, then wait for it to be taken
  task automatic push_tick(input logic arr, input logic [3:0] svc);
    cmd_word_t w;
    w = '0;
    w.arrive = arr;
    w.service_length = svc;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    do @(posedge clk); while (!s_axis_tready);
    ticks_sent++;
    serve_tick(arr, svc);
  endtask

  // stop sending and let every queued result come out
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("mismatch at result %0d: %s expected %0h got %0h", reports_seen, what, want, got);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) note_failure(name, want, got);
  endtask

  task automatic check_report(input report_t want);
    result_t got;
    got = m_axis_tdata;
    compare_field("server_index",  32'(want.word.server_index),  32'(got.server_index));
    compare_field("started",       32'(want.word.started),       32'(got.started));
    compare_field("busy_res",      32'(want.word.busy_res),      32'(got.busy_res));
    compare_field("job_id",        32'(want.word.job_id),        32'(got.job_id));
    compare_field("remaining",     32'(want.word.remaining),     32'(got.remaining));
    compare_field("wait_ticks",    32'(want.word.wait_ticks),    32'(got.wait_ticks));
    compare_field("accum_wait",    want.word.accum_wait,         got.accum_wait);
    compare_field("arrival_count", 32'(want.word.arrival_count), 32'(got.arrival_count));
    compare_field("queue_length",  32'(want.word.queue_length),  32'(got.queue_length));
    compare_field("overflow",      32'(want.word.overflow),      32'(got.overflow));
    compare_field("pad",           32'd0,                        32'(got.pad));
    compare_field("last",          32'(want.last),               32'(m_axis_tlast));
  endtask

  // result side: random back-pressure unless steady is set, changed on the falling edge
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 15);
  end

  // every accepted result is matched against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      reports_seen++;
      if (pending_reports.size() == 0) note_failure("unexpected result", 32'd0, 32'd0);
      else check_report(pending_reports.pop_front());
    end
  end

  // watchdog: too long with no word moving on either side ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    report_t typed_rep;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    q_head = 0;
    q_tail = 0;
    tick_now = '0;
    id_next = '0;
    wait_total = '0;
    for (int s = 0; s < NSRV; s++) begin
      busy_left[s] = '0;
      held_job[s] = '0;
    end
    ticks_sent = 0;
    arrivals_seen = 0;
    drops_seen = 0;
    id_wraps = 0;
    peak_queue = 0;
    reports_seen = 0;
    failures = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows; typed rows replace the predicted server 0 result
    foreach (directed_rows[i]) begin
      push_tick(directed_rows[i].arrive, directed_rows[i].svc);
      if (directed_rows[i].typed) begin
        typed_rep = '0;
        typed_rep.word.started = directed_rows[i].started;
        typed_rep.word.busy_res = directed_rows[i].busy;
        typed_rep.word.job_id = directed_rows[i].job_id;
        typed_rep.word.remaining = directed_rows[i].remaining;
        typed_rep.word.wait_ticks = directed_rows[i].wait_ticks;
        typed_rep.word.accum_wait = directed_rows[i].total;
        typed_rep.word.arrival_count = directed_rows[i].arrivals;
        typed_rep.word.queue_length = directed_rows[i].qlen;
        typed_rep.word.overflow = directed_rows[i].ovf;
        typed_rep.last = (NSRV == 1);
        pending_reports[pending_reports.size() - NSRV] = typed_rep;
      end
    end

    // mixed traffic, about half the ticks carry a job
    repeat (130) push_tick(1'($urandom_range(1)), 4'($urandom_range(15)));

    // sender holds off until the block has emptied its result pipe
    drain_results();

    // flood with mostly long jobs and no idling so that the queue overflows
    steady = 1'b1;
    repeat (180) begin
      if ($urandom_range(99) < 80) push_tick(1'b1, 4'($urandom_range(15, 12)));
      else push_tick(1'b1, 4'($urandom_range(15)));
    end
    steady = 1'b0;

    // sparse arrivals with short jobs drain the queue back down
    repeat (140) push_tick(1'($urandom_range(9) == 0), 4'($urandom_range(2)));

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_reports.size() != 0) begin
      failures += pending_reports.size();
      $display("%0d expected results never arrived", pending_reports.size());
    end
    $display("sent %0d ticks with %0d job arrivals, %0d of them dropped on a full queue",
             ticks_sent, arrivals_seen, drops_seen);
    $display("checked %0d server results, deepest queue %0d jobs, job ids wrapped %0d times",
             reports_seen, peak_queue, id_wraps);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/fmsd_pkg.sv
src/fmsd_front.sv
src/fmsd_back.sv
src/fifo_multi_server_dispatcher.sv
dv/fifo_multi_server_dispatcher_test.sv
